@@ hw/rtl/gbd_pkg.sv @@
// shared constants for the generalized iou distance block
package gbd_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int SIZE_BITS         = 15;
    localparam int AREA_BITS         = 2 * SIZE_BITS;
    localparam int UNION_BITS        = AREA_BITS + 1;

endpackage

@@ hw/rtl/gbd_divider.sv @@
// pipelined restoring fraction divider, one quotient bit per register stage
module gbd_divider #(
    parameter int DW = 31,
    parameter int FB = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [FB-1:0] quo,
    output logic [DW:0]   rem,
    output logic [DW-1:0] den_out
);

    logic [DW:0]   rem_reg  [FB];
    logic [FB-1:0] quo_reg  [FB];
    logic [DW-1:0] den_reg  [FB];
    logic [DW:0]   rem_next [FB];
    logic [FB-1:0] quo_next [FB];

    // returns {quotient bit, new partial remainder}
    function automatic logic [DW+1:0] div_step(logic [DW:0] r, logic [DW-1:0] d);
        logic [DW+1:0] rs;
        logic [DW+1:0] dx;
        logic [DW+1:0] res;
        rs = {r, 1'b0};
        dx = {2'b00, d};
        if (rs >= dx) begin
            res = rs - dx;
            return {1'b1, res[DW:0]};
        end else begin
            return {1'b0, rs[DW:0]};
        end
    endfunction

    always_comb begin
        logic [DW+1:0] st;
        st = div_step({1'b0, num}, den);
        rem_next[0] = st[DW:0];
        quo_next[0] = FB'(st[DW+1]);
        for (int i = 1; i < FB; i++) begin
            st = div_step(rem_reg[i-1], den_reg[i-1]);
            rem_next[i] = st[DW:0];
            quo_next[i] = {quo_reg[i-1][FB-2:0], st[DW+1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
            den_reg[0] <= den;
            for (int i = 1; i < FB; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= den_reg[i-1];
            end
        end
    end

    assign quo     = quo_reg[FB-1];
    assign rem     = rem_reg[FB-1];
    assign den_out = den_reg[FB-1];

endmodule

@@ hw/rtl/giou_box_distance.sv @@
// top level of the generalized iou distance pipeline
// Takes one rectangle pair per clock and returns one minus the generalized IoU with
// FRACTION_BITS fraction bits, truncated, plus a flag when both rectangles are empty
// (distance then 0). In the pipeline, three stages form the areas, intersection and
// enclosing box, one stage per quotient bit in the two parallel restoring dividers,
// then three stages for the exact carry compare of the two remainders. A new pair
// can be taken every cycle; a stall on m_ready freezes the whole pipeline, and
// s_ready is high whenever the output register is empty or being drained.
module giou_box_distance #(
    parameter int COORD_BITS    = gbd_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = gbd_pkg::FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_BITS-1:0]        s_first_left,
    input  logic signed [COORD_BITS-1:0]        s_first_top,
    input  logic [gbd_pkg::SIZE_BITS-1:0]       s_first_width,
    input  logic [gbd_pkg::SIZE_BITS-1:0]       s_first_height,
    input  logic signed [COORD_BITS-1:0]        s_second_left,
    input  logic signed [COORD_BITS-1:0]        s_second_top,
    input  logic [gbd_pkg::SIZE_BITS-1:0]       s_second_width,
    input  logic [gbd_pkg::SIZE_BITS-1:0]       s_second_height,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [FRACTION_BITS+1:0]            m_distance,
    output logic                                m_undefined
);

    import gbd_pkg::*;

    localparam int MW     = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int XW     = MW + 2;
    localparam int SPAN_W = MW + 1;
    localparam int ENC_W  = 2 * SPAN_W;
    localparam int UW     = UNION_BITS;
    localparam int H      = SPAN_W;
    localparam int M1_W   = UW + 1 + H;
    localparam int M2_W   = H + UW;
    localparam int M3_W   = H + 1 + UW;
    localparam int M4_W   = UW + H;
    localparam int P_W    = UW + 1 + ENC_W + 1;
    localparam int FB     = FRACTION_BITS;

    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: box geometry
    logic                  v1_reg;
    logic [SIZE_BITS-1:0]  iw_reg, ih_reg, iw_next, ih_next;
    logic [SPAN_W-1:0]     ew_reg, eh_reg, ew_next, eh_next;
    logic [AREA_BITS-1:0]  a1_reg, a2_reg;
    logic                  emp1_reg, emp2_reg;

    always_comb begin
        logic signed [XW-1:0] l1, t1, l2, t2, r1, b1, r2, b2;
        logic signed [XW-1:0] ix0, ix1, iy0, iy1, ex0, ex1, ey0, ey1, dx, dy;
        l1 = XW'(s_first_left);
        t1 = XW'(s_first_top);
        l2 = XW'(s_second_left);
        t2 = XW'(s_second_top);
        r1 = l1 + signed'(XW'(s_first_width));
        b1 = t1 + signed'(XW'(s_first_height));
        r2 = l2 + signed'(XW'(s_second_width));
        b2 = t2 + signed'(XW'(s_second_height));
        ix0 = (l1 > l2) ? l1 : l2;
        ix1 = (r1 < r2) ? r1 : r2;
        iy0 = (t1 > t2) ? t1 : t2;
        iy1 = (b1 < b2) ? b1 : b2;
        ex0 = (l1 < l2) ? l1 : l2;
        ex1 = (r1 > r2) ? r1 : r2;
        ey0 = (t1 < t2) ? t1 : t2;
        ey1 = (b1 > b2) ? b1 : b2;
        dx = ix1 - ix0;
        dy = iy1 - iy0;
        // a non-positive overlap on either axis gives zero intersection
        iw_next = (dx > 0) ? SIZE_BITS'(dx) : '0;
        ih_next = (dy > 0) ? SIZE_BITS'(dy) : '0;
        ew_next = SPAN_W'(ex1 - ex0);
        eh_next = SPAN_W'(ey1 - ey0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            iw_reg   <= iw_next;
            ih_reg   <= ih_next;
            ew_reg   <= ew_next;
            eh_reg   <= eh_next;
            a1_reg   <= AREA_BITS'(s_first_width) * AREA_BITS'(s_first_height);
            a2_reg   <= AREA_BITS'(s_second_width) * AREA_BITS'(s_second_height);
            emp1_reg <= (s_first_width == '0) || (s_first_height == '0);
            emp2_reg <= (s_second_width == '0) || (s_second_height == '0);
        end
    end

    // stage 2: intersection and enclosing areas
    logic                 v2_reg;
    logic [AREA_BITS-1:0] inter_reg, a1b_reg, a2b_reg;
    logic [ENC_W-1:0]     encl_reg, encl_next;

    always_comb begin
        if (emp1_reg) begin
            encl_next = ENC_W'(a2_reg);
        end else if (emp2_reg) begin
            encl_next = ENC_W'(a1_reg);
        end else begin
            encl_next = ENC_W'(ew_reg) * ENC_W'(eh_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inter_reg <= AREA_BITS'(iw_reg) * AREA_BITS'(ih_reg);
            a1b_reg   <= a1_reg;
            a2b_reg   <= a2_reg;
            encl_reg  <= encl_next;
        end
    end

    // stage 3: union area
    logic                 v3_reg;
    logic [UW-1:0]        uni_reg;
    logic [AREA_BITS-1:0] inter3_reg;
    logic [ENC_W-1:0]     encl3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            uni_reg    <= UW'(a1b_reg) + UW'(a2b_reg) - UW'(inter_reg);
            inter3_reg <= inter_reg;
            encl3_reg  <= encl_reg;
        end
    end

    // dividers
    logic [UW-1:0]    n1;
    logic [ENC_W-1:0] n2;
    logic [FB-1:0]    q1, q2;
    logic [UW:0]      r1;
    logic [ENC_W:0]   r2;
    logic [UW-1:0]    u_d;
    logic [ENC_W-1:0] c_d;

    assign n1 = uni_reg - UW'(inter3_reg);
    assign n2 = encl3_reg - ENC_W'(uni_reg);

    gbd_divider #(.DW(UW), .FB(FB)) u_div_uni (
        .aclk    (aclk),
        .en      (en),
        .num     (n1),
        .den     (uni_reg),
        .quo     (q1),
        .rem     (r1),
        .den_out (u_d)
    );

    gbd_divider #(.DW(ENC_W), .FB(FB)) u_div_encl (
        .aclk    (aclk),
        .en      (en),
        .num     (n2),
        .den     (encl3_reg),
        .quo     (q2),
        .rem     (r2),
        .den_out (c_d)
    );

    logic vd_reg  [FB];
    logic und_reg [FB];

    always_ff @(posedge aclk) begin
        if (en) begin
            und_reg[0] <= (uni_reg == '0);
            for (int i = 1; i < FB; i++) begin
                und_reg[i] <= und_reg[i-1];
            end
        end
    end

    // stage a: partial products for the remainder carry test
    logic            va_reg, unda_reg;
    logic [FB-1:0]   qa1_reg, qa2_reg;
    logic [M1_W-1:0] p_r1cl_reg, p_r1ch_reg;
    logic [M2_W-1:0] p_r2lu_reg;
    logic [M3_W-1:0] p_r2hu_reg;
    logic [M4_W-1:0] p_ucl_reg, p_uch_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            unda_reg   <= und_reg[FB-1];
            qa1_reg    <= q1;
            qa2_reg    <= q2;
            p_r1cl_reg <= M1_W'(r1) * M1_W'(c_d[H-1:0]);
            p_r1ch_reg <= M1_W'(r1) * M1_W'(c_d[ENC_W-1:H]);
            p_r2lu_reg <= M2_W'(r2[H-1:0]) * M2_W'(u_d);
            p_r2hu_reg <= M3_W'(r2[ENC_W:H]) * M3_W'(u_d);
            p_ucl_reg  <= M4_W'(u_d) * M4_W'(c_d[H-1:0]);
            p_uch_reg  <= M4_W'(u_d) * M4_W'(c_d[ENC_W-1:H]);
        end
    end

    // stage b: full products
    logic           vb_reg, undb_reg;
    logic [FB:0]    qsum_reg;
    logic [P_W-1:0] r1c_reg, r2u_reg, uc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            undb_reg <= unda_reg;
            qsum_reg <= (FB+1)'(qa1_reg) + (FB+1)'(qa2_reg);
            r1c_reg  <= P_W'(p_r1cl_reg) + (P_W'(p_r1ch_reg) << H);
            r2u_reg  <= P_W'(p_r2lu_reg) + (P_W'(p_r2hu_reg) << H);
            uc_reg   <= P_W'(p_ucl_reg) + (P_W'(p_uch_reg) << H);
        end
    end

    // output stage: carry when r1/U + r2/C reaches one
    logic                 m_undefined_reg;
    logic [FB+1:0]        m_distance_reg, dist_next;
    logic [P_W:0]         lhs;
    logic                 carry;

    assign lhs   = (P_W+1)'(r1c_reg) + (P_W+1)'(r2u_reg);
    assign carry = (lhs >= (P_W+1)'(uc_reg));

    always_comb begin
        if (undb_reg) begin
            dist_next = '0;
        end else begin
            dist_next = (FB+2)'(qsum_reg) + (FB+2)'(carry);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_distance_reg  <= dist_next;
            m_undefined_reg <= undb_reg;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < FB; i++) begin
                vd_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < FB; i++) begin
                vd_reg[i] <= vd_reg[i-1];
            end
            va_reg      <= vd_reg[FB-1];
            vb_reg      <= va_reg;
            m_valid_reg <= vb_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_distance  = m_distance_reg;
    assign m_undefined = m_undefined_reg;

endmodule

@@ hw/rtl/gbd_checker.sv @@
// port-level checks for the generalized iou distance block, bound to the top level
module gbd_checker #(
    parameter int FRACTION_BITS = gbd_pkg::FRACTION_BITS_DEF
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [FRACTION_BITS+1:0] m_distance,
    input logic                     m_undefined
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance) && $stable(m_undefined))
        else $error("stalled result changed");

    // undefined results carry zero distance
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_undefined |-> m_distance == '0)
        else $error("undefined result with nonzero distance");

    // input side only stalls behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input stall without held result");

    // nothing comes out right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind giou_box_distance gbd_checker #(.FRACTION_BITS(FRACTION_BITS)) u_gbd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_distance  (m_distance),
    .m_undefined (m_undefined)
);
